/* src/jsu_pkg.sv */
`timescale 1ns / 1ps
// jsu_pkg: shared types, constants and helper functions for the JSON string unescaper.
// Used by jsu_decode, jsu_serializer, json_string_unescape_utf8 and tb_top; depends on nothing.
package jsu_pkg;

	// length counter width and derived limits
	localparam int LEN_W     = 17;
	localparam int CAP_W     = 16;
	localparam int TOTAL_W   = 17;
	localparam int CMP_W     = (LEN_W > CAP_W) ? LEN_W : CAP_W;
	localparam int MAX_BYTES = 4;

	// configuration register indexes
	localparam logic CFG_CAPACITY     = 1'b0;
	localparam logic CFG_MEASURE_ONLY = 1'b1;

	// characters that matter to the escape decoder
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_B      = 8'h62;
	localparam logic [7:0] CH_F      = 8'h66;
	localparam logic [7:0] CH_N      = 8'h6E;
	localparam logic [7:0] CH_R      = 8'h72;
	localparam logic [7:0] CH_T      = 8'h74;
	localparam logic [7:0] CH_U      = 8'h75;

	// surrogate ranges
	localparam logic [15:0] HI_SUR_FIRST = 16'hD800;
	localparam logic [15:0] HI_SUR_LAST  = 16'hDBFF;
	localparam logic [15:0] LO_SUR_FIRST = 16'hDC00;
	localparam logic [15:0] LO_SUR_LAST  = 16'hDFFF;

	typedef enum logic [2:0] {
		MODE_NORMAL,
		MODE_ESCAPE,
		MODE_HEX_FIRST,
		MODE_WANT_BSLASH,
		MODE_WANT_U,
		MODE_HEX_LOW
	} mode_t;

	typedef enum logic [1:0] {
		STATUS_OK,
		STATUS_INVALID,
		STATUS_TOO_SMALL
	} status_t;

	// per-string decode state
	typedef struct packed {
		mode_t             mode;
		logic [1:0]        hex_cnt;
		logic [15:0]       acc;
		logic [9:0]        hi;
		logic [LEN_W-1:0]  len;
		logic              err;
	} st_t;

	// all results caused by one input item
	typedef struct packed {
		logic [2:0]                   cnt;
		logic                         bvalid;
		logic [MAX_BYTES-1:0][7:0]    bytes;
		logic [MAX_BYTES-1:0]         kept;
		logic                         done;
		status_t                      status;
		logic [TOTAL_W-1:0]           total;
	} grp_t;

	// one result item
	typedef struct packed {
		logic [7:0]          out_byte;
		logic                bvalid;
		logic                kept;
		logic                run_last;
		logic                done;
		status_t             status;
		logic [TOTAL_W-1:0]  total;
	} res_t;

	// utf-8 encoding of one code point
	typedef struct packed {
		logic [2:0]                 n;
		logic [MAX_BYTES-1:0][7:0]  b;
	} utf8_t;

	// hex digit value, bit 4 set when the character is a hex digit
	function automatic logic [4:0] hex_val(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= 8'h30 && c <= 8'h39)      r = {1'b1, 4'(c - 8'h30)};
		else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
		else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
		return r;
	endfunction

	function automatic utf8_t utf8_enc(input logic [20:0] cp);
		utf8_t r;
		r = '0;
		if (cp < 21'h80) begin
			r.n    = 3'd1;
			r.b[0] = cp[7:0];
		end else if (cp < 21'h800) begin
			r.n    = 3'd2;
			r.b[0] = {3'b110, cp[10:6]};
			r.b[1] = {2'b10, cp[5:0]};
		end else if (cp < 21'h10000) begin
			r.n    = 3'd3;
			r.b[0] = {4'b1110, cp[15:12]};
			r.b[1] = {2'b10, cp[11:6]};
			r.b[2] = {2'b10, cp[5:0]};
		end else begin
			r.n    = 3'd4;
			r.b[0] = {5'b11110, cp[20:18]};
			r.b[1] = {2'b10, cp[17:12]};
			r.b[2] = {2'b10, cp[11:6]};
			r.b[3] = {2'b10, cp[5:0]};
		end
		return r;
	endfunction

	// length plus a small step, saturating at the counter maximum
	function automatic logic [LEN_W-1:0] len_add(input logic [LEN_W-1:0] l, input logic [2:0] d);
		logic [LEN_W:0] s;
		s = {1'b0, l} + (LEN_W+1)'(d);
		if (s[LEN_W]) return {LEN_W{1'b1}};
		return s[LEN_W-1:0];
	endfunction

	// length reported on the final result, masked to the output width
	function automatic logic [TOTAL_W-1:0] to_total(input logic [LEN_W-1:0] l);
		logic [LEN_W+TOTAL_W-1:0] w;
		w = (LEN_W+TOTAL_W)'(l);
		return w[TOTAL_W-1:0];
	endfunction

endpackage

/* src/jsu_decode.sv */
`timescale 1ns / 1ps
// jsu_decode: escape and surrogate decoder for one registered input byte.
// Depends on jsu_pkg; produces the result group and the next decode state.
module jsu_decode (
	input  logic [7:0]                 in_byte,
	input  logic                       last,
	input  jsu_pkg::st_t               st,
	input  logic [jsu_pkg::CAP_W-1:0]  capacity,
	input  logic                       measure_only,
	output logic                       has_result,
	output jsu_pkg::grp_t              grp,
	output jsu_pkg::st_t               nst
);

	logic [4:0]                          hv;
	logic [15:0]                         acc_new;
	logic                                hex_done;
	logic [20:0]                         pair_cp;
	jsu_pkg::utf8_t                      enc;
	logic [2:0]                          n;
	logic [jsu_pkg::MAX_BYTES-1:0][7:0]  bytes;
	logic                                err;
	logic [jsu_pkg::LEN_W-1:0]           len_new;
	logic [jsu_pkg::LEN_W-1:0]           idx [jsu_pkg::MAX_BYTES];
	logic [jsu_pkg::MAX_BYTES-1:0]       kept;
	logic                                too_small;

	// hex digit accumulation shared by both \u states
	assign hv       = jsu_pkg::hex_val(in_byte);
	assign acc_new  = {st.acc[11:0], hv[3:0]};
	assign hex_done = hv[4] && (st.hex_cnt == 2'd3);
	assign pair_cp  = {11'({1'b0, st.hi} + 11'd64), acc_new[9:0]};

	// mode machine: bytes emitted and next state
	always_comb begin
		nst   = st;
		n     = 3'd0;
		bytes = '0;
		err   = st.err;
		enc   = '0;
		if (!st.err) begin
			unique case (st.mode) inside
				jsu_pkg::MODE_NORMAL: begin
					if (in_byte == jsu_pkg::CH_BSLASH) begin
						nst.mode = jsu_pkg::MODE_ESCAPE;
					end else begin
						n        = 3'd1;
						bytes[0] = in_byte;
					end
				end
				jsu_pkg::MODE_ESCAPE: begin
					nst.mode = jsu_pkg::MODE_NORMAL;
					n        = 3'd1;
					case (in_byte) inside
						jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSLASH, jsu_pkg::CH_SLASH:
							bytes[0] = in_byte;
						jsu_pkg::CH_B: bytes[0] = 8'h08;
						jsu_pkg::CH_F: bytes[0] = 8'h0C;
						jsu_pkg::CH_N: bytes[0] = 8'h0A;
						jsu_pkg::CH_R: bytes[0] = 8'h0D;
						jsu_pkg::CH_T: bytes[0] = 8'h09;
						jsu_pkg::CH_U: begin
							n           = 3'd0;
							nst.mode    = jsu_pkg::MODE_HEX_FIRST;
							nst.hex_cnt = 2'd0;
							nst.acc     = 16'd0;
						end
						default: begin
							n   = 3'd0;
							err = 1'b1;
						end
					endcase
				end
				jsu_pkg::MODE_HEX_FIRST, jsu_pkg::MODE_HEX_LOW: begin
					if (!hv[4]) begin
						err = 1'b1;
					end else begin
						nst.acc     = acc_new;
						nst.hex_cnt = hex_done ? 2'd0 : st.hex_cnt + 2'd1;
						if (hex_done && st.mode == jsu_pkg::MODE_HEX_FIRST) begin
							if (acc_new >= jsu_pkg::HI_SUR_FIRST &&
									acc_new <= jsu_pkg::HI_SUR_LAST) begin
								nst.hi   = acc_new[9:0];
								nst.mode = jsu_pkg::MODE_WANT_BSLASH;
							end else if (acc_new >= jsu_pkg::LO_SUR_FIRST &&
									acc_new <= jsu_pkg::LO_SUR_LAST) begin
								err = 1'b1;
							end else begin
								nst.mode = jsu_pkg::MODE_NORMAL;
								enc      = jsu_pkg::utf8_enc({5'd0, acc_new});
								n        = enc.n;
								bytes    = enc.b;
							end
						end else if (hex_done) begin
							if (acc_new < jsu_pkg::LO_SUR_FIRST ||
									acc_new > jsu_pkg::LO_SUR_LAST) begin
								err = 1'b1;
							end else begin
								nst.mode = jsu_pkg::MODE_NORMAL;
								enc      = jsu_pkg::utf8_enc(pair_cp);
								n        = enc.n;
								bytes    = enc.b;
							end
						end
					end
				end
				jsu_pkg::MODE_WANT_BSLASH: begin
					if (in_byte == jsu_pkg::CH_BSLASH) nst.mode = jsu_pkg::MODE_WANT_U;
					else err = 1'b1;
				end
				jsu_pkg::MODE_WANT_U: begin
					if (in_byte == jsu_pkg::CH_U) begin
						nst.mode    = jsu_pkg::MODE_HEX_LOW;
						nst.hex_cnt = 2'd0;
						nst.acc     = 16'd0;
					end else begin
						err = 1'b1;
					end
				end
				default: err = 1'b1;
			endcase
			// string ends inside an escape
			if (last && !err && nst.mode != jsu_pkg::MODE_NORMAL) err = 1'b1;
		end
		nst.err = err;
		nst.len = jsu_pkg::len_add(st.len, n);
		// everything returns to idle after the final byte
		if (last) nst = '0;
	end

	// byte indexes and kept flags, one per emitted byte
	always_comb begin
		for (int i = 0; i < jsu_pkg::MAX_BYTES; i++) begin
			idx[i]  = jsu_pkg::len_add(st.len, 3'(i));
			kept[i] = !measure_only && (i < int'(n)) &&
				(jsu_pkg::CMP_W'(idx[i]) < jsu_pkg::CMP_W'(capacity));
		end
	end

	assign len_new   = jsu_pkg::len_add(st.len, n);
	assign too_small = !measure_only &&
		(jsu_pkg::CMP_W'(len_new) > jsu_pkg::CMP_W'(capacity));

	// result group
	always_comb begin
		has_result = (n != 3'd0) || last;
		grp        = '0;
		grp.cnt    = (n == 3'd0) ? 3'd1 : n;
		grp.bvalid = (n != 3'd0);
		grp.bytes  = bytes;
		grp.kept   = kept;
		grp.done   = last;
		if (last) begin
			grp.total = jsu_pkg::to_total(len_new);
			if (err) grp.status = jsu_pkg::STATUS_INVALID;
			else if (too_small) grp.status = jsu_pkg::STATUS_TOO_SMALL;
			else grp.status = jsu_pkg::STATUS_OK;
		end
	end

endmodule

/* src/jsu_serializer.sv */
`timescale 1ns / 1ps
// jsu_serializer: group register that hands out its items one per cycle while res_ready is high, with a one-deep skid.
// Depends on jsu_pkg.
module jsu_serializer (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           load,
	input  jsu_pkg::grp_t  grp_in,
	output logic           free,
	output logic           res_valid,
	input  logic           res_ready,
	output jsu_pkg::res_t  res
);

	jsu_pkg::grp_t  grp_s2;
	logic           vld_s2;
	logic [1:0]     idx_q;
	jsu_pkg::grp_t  grp_skid_q;
	logic           vld_skid_q;
	logic           at_last;
	logic           fire;
	logic           head_free;
	logic           skid_load;

	assign at_last   = ({1'b0, idx_q} == grp_s2.cnt - 3'd1);
	assign fire      = vld_s2 && res_ready;
	assign head_free = !vld_s2 || (res_ready && at_last);
	assign free      = !vld_skid_q || head_free;
	// a new group parks in the skid while the head is busy or the skid moves up
	assign skid_load = load && (vld_skid_q || !head_free);

	// head group valid and position within the group
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			idx_q  <= 2'd0;
		end else if (head_free) begin
			vld_s2 <= vld_skid_q || load;
			idx_q  <= 2'd0;
		end else if (fire) begin
			idx_q <= idx_q + 2'd1;
		end
	end

	// head group payload, the skid goes first
	always_ff @(posedge clk) begin
		if (head_free) begin
			if (vld_skid_q) grp_s2 <= grp_skid_q;
			else if (load) grp_s2 <= grp_in;
		end
	end

	// skid valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_skid_q <= 1'b0;
		end else if (skid_load) begin
			vld_skid_q <= 1'b1;
		end else if (head_free) begin
			vld_skid_q <= 1'b0;
		end
	end

	// skid payload
	always_ff @(posedge clk) begin
		if (skid_load) grp_skid_q <= grp_in;
	end

	// current item of the group; done fields only on its last item
	always_comb begin
		res          = '0;
		res.out_byte = grp_s2.bytes[idx_q];
		res.bvalid   = grp_s2.bvalid;
		res.kept     = grp_s2.kept[idx_q];
		res.run_last = at_last;
		if (at_last && grp_s2.done) begin
			res.done   = 1'b1;
			res.status = grp_s2.status;
			res.total  = grp_s2.total;
		end
	end

	assign res_valid = vld_s2;

endmodule

/* src/json_string_unescape_utf8.sv */
`timescale 1ns / 1ps
// json_string_unescape_utf8: JSON string body to UTF-8 unescaper, top level.
// Depends on jsu_pkg, jsu_decode and jsu_serializer.
//
//  channel  dir  handshake              payload
//  s_*      in   s_tvalid / s_tready    s_tdata = in_byte, s_tlast = end_of_string
//  m_*      out  m_tvalid / m_tready    m_tdata, m_tuser, m_tlast = run_last
//  cfg_*    in   cfg_valid / cfg_ready  cfg_index, cfg_data
//
// An input item is registered, decoded in one pass and its results (up to four) land in
// the group register, from which the first result is taken. The group drains one result
// per cycle while m_tready is high. A one-deep skid takes the next group while the head
// drains, so the input can take new items meanwhile; a group of several results followed
// at once by items with results stalls the input. A stalled m_tready holds the groups.
// Reset clears the decode state and valids, capacity to 65535, measure_only to 0.
module json_string_unescape_utf8 (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [7:0]   s_tdata,   // [7:0] in_byte
	input  logic         s_tlast,
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [31:0]  m_tdata,   // [7:0] out_byte, [8] kept, [10:9] status,
	                                // [27:11] total_length, [31:28] zero
	output logic [1:0]   m_tuser,   // [0] byte_valid, [1] done_res
	output logic         m_tlast,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic         cfg_index,
	input  logic [15:0]  cfg_data
);

	logic [jsu_pkg::CAP_W-1:0]  capacity_q;
	logic                       measure_only_q;
	logic                       vld_s1;
	logic [7:0]                 byte_s1;
	logic                       last_s1;
	jsu_pkg::st_t               st_q;
	jsu_pkg::st_t               nst;
	jsu_pkg::grp_t              grp;
	jsu_pkg::res_t              res;
	logic                       has_result;
	logic                       ser_free;
	logic                       adv;

	// configuration registers
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q     <= {jsu_pkg::CAP_W{1'b1}};
			measure_only_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == jsu_pkg::CFG_CAPACITY) capacity_q <= cfg_data;
			if (cfg_index == jsu_pkg::CFG_MEASURE_ONLY) measure_only_q <= cfg_data[0];
		end
	end

	// the registered item moves on when it has no result or the serializer can take its group
	assign adv      = vld_s1 && (!has_result || ser_free);
	assign s_tready = !vld_s1 || adv;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	// decode state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (adv) begin
			st_q <= nst;
		end
	end

	jsu_decode u_decode (
		.in_byte      (byte_s1),
		.last         (last_s1),
		.st           (st_q),
		.capacity     (capacity_q),
		.measure_only (measure_only_q),
		.has_result   (has_result),
		.grp          (grp),
		.nst          (nst)
	);

	jsu_serializer u_serializer (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (adv && has_result),
		.grp_in    (grp),
		.free      (ser_free),
		.res_valid (m_tvalid),
		.res_ready (m_tready),
		.res       (res)
	);

	// output packing
	assign m_tdata = {4'd0, res.total, res.status, res.kept, res.out_byte};
	assign m_tuser = {res.done, res.bvalid};
	assign m_tlast = res.run_last;

`ifndef SYNTH
	// the final result of a string always closes its run
	a_done_is_run_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[1]) |-> m_tlast)
		else $error("done result without run_last");

	// status and length stay zero away from the final result
	a_status_only_on_done: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser[1]) |-> (m_tdata[27:9] == 19'd0))
		else $error("status or length on a non-final result");

	// the decode state is back to idle after the final byte
	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && last_s1) |=> (st_q.len == '0 && st_q.mode == jsu_pkg::MODE_NORMAL &&
			!st_q.err))
		else $error("decode state not cleared after final byte");
`endif

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// tb_top: self-checking bench for json_string_unescape_utf8, directed strings then random ones,
// with random stalls on both streams. Depends on jsu_pkg and the json_string_unescape_utf8 top.
module tb_top;
	import jsu_pkg::*;

	localparam int QUIET_LIMIT = 3000;
	localparam int SETTLE      = 8;
	localparam int LONG_HOLD   = 200;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata   = 8'h00;
	logic        s_tlast   = 1'b0;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [31:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        m_tlast;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_index = CFG_CAPACITY;
	logic [15:0] cfg_data  = 16'h0000;

	json_string_unescape_utf8 dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// decoder state mirrored by the bench
	mode_t            dec_mode;
	logic [1:0]       dec_hex_cnt;
	logic [15:0]      dec_acc;
	logic [9:0]       dec_hi;
	logic [LEN_W-1:0] dec_len;
	logic             dec_err;
	logic [15:0]      cap_val;
	logic             meas_val;

	logic [7:0] step_bytes[$];
	logic       step_kept[$];
	res_t       expected_q[$];
	logic [7:0] str_q[$];

	logic [7:0] esc_letters[8] = '{CH_QUOTE, CH_BSLASH, CH_SLASH, CH_B, CH_F, CH_N, CH_R, CH_T};

	bit src_idle_en  = 1'b1;
	bit sink_idle_en = 1'b1;
	bit hold_request = 1'b0;

	int items_sent      = 0;
	int decoded_items   = 0;
	int strings_sent    = 0;
	int results_checked = 0;
	int mismatches      = 0;
	int quiet_cycles    = 0;

	// gap length: mostly none, some short, a few long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65) return 0;
		if (r < 93) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic int nibble_of(input logic [7:0] c);
		if (c >= "0" && c <= "9") return c - "0";
		if (c >= "a" && c <= "f") return c - "a" + 10;
		if (c >= "A" && c <= "F") return c - "A" + 10;
		return -1;
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] v, input logic upper);
		if (v < 4'd10) return 8'h30 + 8'(v);
		return (upper ? 8'h41 : 8'h61) + 8'(v) - 8'd10;
	endfunction

	function automatic bit is_escape_letter(input logic [7:0] c);
		for (int i = 0; i < 8; i++)
			if (c == esc_letters[i]) return 1'b1;
		return c == CH_U;
	endfunction

	task automatic clear_decoder();
		dec_mode    = MODE_NORMAL;
		dec_hex_cnt = 2'd0;
		dec_acc     = 16'h0000;
		dec_hi      = 10'h000;
		dec_len     = '0;
		dec_err     = 1'b0;
	endtask

	// one output byte, kept flag taken against the index before counting
	task automatic put_byte(input logic [7:0] b);
		step_bytes.push_back(b);
		step_kept.push_back(!meas_val && dec_len < cap_val);
		if (dec_len != '1) dec_len = dec_len + 1'b1;
	endtask

	task automatic put_code(input logic [20:0] cp);
		if (cp < 21'h80) begin
			put_byte(cp[7:0]);
		end else if (cp < 21'h800) begin
			put_byte(8'hC0 | cp[10:6]);
			put_byte(8'h80 | cp[5:0]);
		end else if (cp < 21'h10000) begin
			put_byte(8'hE0 | cp[15:12]);
			put_byte(8'h80 | cp[11:6]);
			put_byte(8'h80 | cp[5:0]);
		end else begin
			put_byte(8'hF0 | cp[20:18]);
			put_byte(8'h80 | cp[17:12]);
			put_byte(8'h80 | cp[11:6]);
			put_byte(8'h80 | cp[5:0]);
		end
	endtask

	task automatic take_digit(input logic [7:0] c, output logic complete);
		int v;
		complete = 1'b0;
		v = nibble_of(c);
		if (v < 0) begin
			dec_err = 1'b1;
		end else begin
			dec_acc = {dec_acc[11:0], v[3:0]};
			if (dec_hex_cnt == 2'd3) begin
				dec_hex_cnt = 2'd0;
				complete = 1'b1;
			end else begin
				dec_hex_cnt = dec_hex_cnt + 1'b1;
			end
		end
	endtask

	// advance the mirrored decoder by one input item and queue its results
	task automatic unescape_item(input logic [7:0] c, input logic last);
		logic complete;
		res_t r;
		int   n;
		step_bytes.delete();
		step_kept.delete();
		if (!dec_err) begin
			case (dec_mode)
				MODE_NORMAL: begin
					if (c == CH_BSLASH) dec_mode = MODE_ESCAPE;
					else put_byte(c);
				end
				MODE_ESCAPE: begin
					dec_mode = MODE_NORMAL;
					case (c)
						CH_QUOTE, CH_BSLASH, CH_SLASH: put_byte(c);
						CH_B: put_byte(8'h08);
						CH_F: put_byte(8'h0C);
						CH_N: put_byte(8'h0A);
						CH_R: put_byte(8'h0D);
						CH_T: put_byte(8'h09);
						CH_U: begin
							dec_mode    = MODE_HEX_FIRST;
							dec_hex_cnt = 2'd0;
							dec_acc     = 16'h0000;
						end
						default: dec_err = 1'b1;
					endcase
				end
				MODE_HEX_FIRST: begin
					take_digit(c, complete);
					if (complete) begin
						if (dec_acc >= HI_SUR_FIRST && dec_acc <= HI_SUR_LAST) begin
							dec_hi   = dec_acc[9:0];
							dec_mode = MODE_WANT_BSLASH;
						end else if (dec_acc >= LO_SUR_FIRST && dec_acc <= LO_SUR_LAST) begin
							dec_err = 1'b1;
						end else begin
							dec_mode = MODE_NORMAL;
							put_code({5'd0, dec_acc});
						end
					end
				end
				MODE_WANT_BSLASH: begin
					if (c == CH_BSLASH) dec_mode = MODE_WANT_U;
					else dec_err = 1'b1;
				end
				MODE_WANT_U: begin
					if (c == CH_U) begin
						dec_mode    = MODE_HEX_LOW;
						dec_hex_cnt = 2'd0;
						dec_acc     = 16'h0000;
					end else begin
						dec_err = 1'b1;
					end
				end
				MODE_HEX_LOW: begin
					take_digit(c, complete);
					if (complete) begin
						if (dec_acc < LO_SUR_FIRST || dec_acc > LO_SUR_LAST) begin
							dec_err = 1'b1;
						end else begin
							dec_mode = MODE_NORMAL;
							put_code(21'h10000 + {1'b0, dec_hi, dec_acc[9:0]});
						end
					end
				end
				default: dec_err = 1'b1;
			endcase
			// string ending inside an escape
			if (last && !dec_err && dec_mode != MODE_NORMAL) dec_err = 1'b1;
		end

		n = step_bytes.size();
		if (last && n == 0) begin
			step_bytes.push_back(8'h00);
			step_kept.push_back(1'b0);
		end
		for (int i = 0; i < step_bytes.size(); i++) begin
			r          = '0;
			r.out_byte = step_bytes[i];
			r.bvalid   = (n > 0);
			r.kept     = step_kept[i];
			r.status   = STATUS_OK;
			if (i == step_bytes.size() - 1) begin
				r.run_last = 1'b1;
				if (last) begin
					r.done  = 1'b1;
					r.total = TOTAL_W'(dec_len);
					if (dec_err) r.status = STATUS_INVALID;
					else if (!meas_val && dec_len > cap_val) r.status = STATUS_TOO_SMALL;
				end
			end
			expected_q.push_back(r);
		end
		if (last) clear_decoder();
	endtask

	// offer one item after an optional gap and wait for it to be taken
	task automatic send_item(input logic [7:0] c, input logic last);
		int gap;
		gap = src_idle_en ? pick_gap() : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= c;
		s_tlast  <= last;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		items_sent++;
		if (!dec_err) decoded_items++;
		unescape_item(c, last);
	endtask

	task automatic send_str();
		for (int i = 0; i < str_q.size(); i++)
			send_item(str_q[i], i == str_q.size() - 1);
		strings_sent++;
		str_q.delete();
	endtask

	// input idle, results drained, block given time to settle
	task automatic end_phase();
		s_tvalid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_config(input logic [15:0] cap, input logic meas);
		cfg_valid <= 1'b1;
		cfg_index <= CFG_CAPACITY;
		cfg_data  <= cap;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cap_val = cap;
		cfg_index <= CFG_MEASURE_ONLY;
		cfg_data  <= {15'd0, meas};
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		meas_val = meas;
		cfg_valid <= 1'b0;
	endtask

	task automatic add_text(input string s);
		for (int i = 0; i < s.len(); i++) str_q.push_back(s[i]);
	endtask

	task automatic add_hex4(input logic [15:0] v);
		str_q.push_back(CH_BSLASH);
		str_q.push_back(CH_U);
		for (int i = 3; i >= 0; i--)
			str_q.push_back(hex_char(v[i*4 +: 4], 1'($urandom_range(0, 1))));
	endtask

	function automatic logic [15:0] rand_high();
		return HI_SUR_FIRST + 16'($urandom_range(0, 16'h3FF));
	endfunction

	function automatic logic [15:0] rand_low();
		return LO_SUR_FIRST + 16'($urandom_range(0, 16'h3FF));
	endfunction

	// malformed escapes of six kinds
	task automatic add_broken();
		logic [7:0] c;
		int         k;
		case ($urandom_range(0, 5))
			0: begin
				do c = 8'($urandom_range(0, 255)); while (is_escape_letter(c));
				str_q.push_back(CH_BSLASH);
				str_q.push_back(c);
			end
			1: begin
				k = $urandom_range(0, 3);
				str_q.push_back(CH_BSLASH);
				str_q.push_back(CH_U);
				repeat (k) str_q.push_back(hex_char(4'($urandom_range(0, 15)),
					1'($urandom_range(0, 1))));
				do c = 8'($urandom_range(0, 255)); while (nibble_of(c) >= 0);
				str_q.push_back(c);
			end
			2: add_hex4(rand_low());
			3: begin
				add_hex4(rand_high());
				do c = 8'($urandom_range(0, 255)); while (c == CH_BSLASH);
				str_q.push_back(c);
			end
			4: begin
				add_hex4(rand_high());
				str_q.push_back(CH_BSLASH);
				do c = 8'($urandom_range(0, 255)); while (c == CH_U);
				str_q.push_back(c);
			end
			default: begin
				add_hex4(rand_high());
				add_hex4(16'($urandom_range(0, 16'hDBFF)));
			end
		endcase
	endtask

	// mostly well-formed tokens, some broken ones, sometimes cut short
	task automatic build_random_string();
		int         ntok;
		int         kind;
		int         start;
		int         keep;
		logic [7:0] b;
		logic [15:0] cp;
		ntok  = $urandom_range(1, 6);
		start = 0;
		for (int t = 0; t < ntok; t++) begin
			start = str_q.size();
			kind  = $urandom_range(0, 99);
			if (kind < 35) begin
				b = 8'($urandom_range(0, 255));
				if (b == CH_BSLASH) b = b ^ 8'h01;
				str_q.push_back(b);
			end else if (kind < 55) begin
				str_q.push_back(CH_BSLASH);
				str_q.push_back(esc_letters[$urandom_range(0, 7)]);
			end else if (kind < 75) begin
				case ($urandom_range(0, 2))
					0: cp = 16'($urandom_range(0, 16'h7F));
					1: cp = 16'($urandom_range(16'h80, 16'h7FF));
					default: begin
						cp = 16'($urandom_range(16'h800, 16'hF7FF));
						if (cp >= HI_SUR_FIRST) cp = cp + 16'h800;
					end
				endcase
				add_hex4(cp);
			end else if (kind < 88) begin
				add_hex4(rand_high());
				add_hex4(rand_low());
			end else begin
				add_broken();
			end
		end
		if ($urandom_range(0, 9) == 0 && str_q.size() - start > 1) begin
			keep = start + int'($urandom_range(1, str_q.size() - start - 1));
			while (str_q.size() > keep) void'(str_q.pop_back());
		end
	endtask

	task automatic run_random(input int target);
		int first;
		first = decoded_items;
		while (decoded_items - first < target) begin
			build_random_string();
			send_str();
		end
	endtask

	// every simple escape plus byte extremes in one string
	task automatic test_escapes();
		str_q.push_back(8'h00);
		str_q.push_back(8'hFF);
		add_text("\\\"\\\\\\/\\b\\f\\n\\r\\t");
		send_str();
		end_phase();
	endtask

	// top of the code space from a surrogate pair, then a string cut inside an escape
	task automatic test_surrogates();
		add_text("\\uDBFF\\udfff");
		send_str();
		add_text("\\");
		send_str();
		end_phase();
	endtask

	task automatic test_random_traffic();
		run_random(30);
		end_phase();
	endtask

	// output held off while the sender keeps offering
	task automatic test_backpressure();
		src_idle_en  = 1'b0;
		hold_request = 1'b1;
		run_random(25);
		src_idle_en  = 1'b1;
		end_phase();
	endtask

	task automatic test_small_buffer();
		write_config(16'd0, 1'b0);
		run_random(15);
		end_phase();
		write_config(16'($urandom_range(1, 12)), 1'b0);
		run_random(15);
		end_phase();
	endtask

	task automatic test_measure_only();
		write_config(16'd0, 1'b1);
		run_random(15);
		end_phase();
		write_config(16'hFFFF, 1'b1);
		run_random(15);
		end_phase();
	endtask

	task automatic test_no_idling();
		write_config(16'($urandom_range(1, 40)), 1'b0);
		src_idle_en  = 1'b0;
		sink_idle_en = 1'b0;
		run_random(20);
		end_phase();
		src_idle_en  = 1'b1;
		sink_idle_en = 1'b1;
	endtask

	// output side: random stalls, plus one long hold on request
	initial begin : sink_side
		int n;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				n = LONG_HOLD;
			end else begin
				n = sink_idle_en ? pick_gap() : 0;
			end
			if (n > 0) begin
				m_tready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			m_tready <= 1'b1;
		end
	end

	// compare each result item with the oldest expectation
	always @(posedge clk) begin : result_check
		res_t got;
		res_t want;
		if (m_tvalid && m_tready) begin
			got.out_byte = m_tdata[7:0];
			got.kept     = m_tdata[8];
			got.status   = status_t'(m_tdata[10:9]);
			got.total    = m_tdata[27:11];
			got.bvalid   = m_tuser[0];
			got.done     = m_tuser[1];
			got.run_last = m_tlast;
			results_checked++;
			if (expected_q.size() == 0) begin
				if (mismatches < 10)
					$display("unexpected result %0d: byte %02h valid %0b done %0b",
						results_checked, got.out_byte, got.bvalid, got.done);
				mismatches++;
			end else begin
				want = expected_q.pop_front();
				if (got.out_byte !== want.out_byte || got.bvalid !== want.bvalid ||
					got.kept !== want.kept || got.run_last !== want.run_last ||
					got.done !== want.done || got.status !== want.status ||
					got.total !== want.total) begin
					if (mismatches < 10) begin
						$display("result %0d expected: byte %02h valid %0b kept %0b last %0b",
							results_checked, want.out_byte, want.bvalid, want.kept,
							want.run_last);
						$display("    done %0b status %0d total %0d", want.done,
							want.status, want.total);
						$display("result %0d got     : byte %02h valid %0b kept %0b last %0b",
							results_checked, got.out_byte, got.bvalid, got.kept,
							got.run_last);
						$display("    done %0b status %0d total %0d", got.done,
							got.status, got.total);
					end
					mismatches++;
				end
			end
		end
	end

	// stop a hung run: nothing accepted on any channel for too long
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("timeout: no item moved for %0d cycles, %0d results outstanding",
				quiet_cycles, expected_q.size());
			$display("*** FAILED ***");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		clear_decoder();
		cap_val  = 16'hFFFF;
		meas_val = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_escapes();
		test_surrogates();
		test_random_traffic();
		test_backpressure();
		test_small_buffer();
		test_measure_only();
		test_no_idling();

		end_phase();
		mismatches += expected_q.size();
		$display("ran %0d strings, %0d input items, %0d result items checked",
			strings_sent, items_sent, results_checked);
		$display("escapes, unicode and surrogates, malformed input, capacity and measure-only");
		if (mismatches == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("%0d failures", mismatches);
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

/* sim.f */
src/jsu_pkg.sv
src/jsu_decode.sv
src/jsu_serializer.sv
src/json_string_unescape_utf8.sv
sim/tb_top.sv
